/* rtl/polyphase_arbitrary_resampler_macros.svh */
// Assertion macros for the polyphase resampler checker.
// Needs a clk and an active-high synchronous rst in the scope of use.
`ifndef POLYPHASE_ARBITRARY_RESAMPLER_MACROS_SVH
`define POLYPHASE_ARBITRARY_RESAMPLER_MACROS_SVH

// check while out of reset
`define PAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check on every edge, reset included
`define PAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/par_pkg.sv */
// Shared constants and types for the polyphase arbitrary resampler.
// No dependencies.
package par_pkg;

  localparam int DEF_NUM_PHASES     = 32;
  localparam int DEF_TAPS_PER_PHASE = 16;
  localparam int DEF_SAMPLE_BITS    = 16;
  localparam int DEF_COEF_BITS      = 18;

  localparam int STORE_DEPTH = 512;
  localparam int ADDR_W      = 9;
  localparam int LEN_W       = 10;
  localparam int ISTEP_W     = 6;
  localparam int FRAC_W      = 32;
  localparam int MAX_OUT     = 32;
  localparam int CNT_W       = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INT_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROTO_LEN = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TAP    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RA, S_RB, S_HD, S_M0, S_M1, S_M2, S_M3,
    S_DRAIN, S_SC, S_SUM, S_EMIT, S_WRAP
  } state_t;

endpackage

/* rtl/par_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module par_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/par_fifo.sv */
// Small register queue with full/empty flags.
// Depends on nothing but its parameters.
module par_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      count;
  logic             do_wr, do_rd;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end
endmodule

/* rtl/par_front.sv */
// Front end: accepts input transactions, packs them by kind into a short queue.
// Depends on par_pkg and par_fifo.
module par_front #(
  parameter int SAMPLE_BITS = par_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS   = par_pkg::DEF_COEF_BITS,
  parameter int PL_W        = 1 + 2 * par_pkg::DEF_SAMPLE_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  input  logic [par_pkg::ADDR_W-1:0]  tap_index,
  input  logic signed [COEF_BITS-1:0] tap_value,
  output logic                        q_valid,
  output logic [PL_W-1:0]             q_data,
  input  logic                        q_pop
);
  import par_pkg::*;

  logic [PL_W-1:0] packed_item;
  logic            q_empty;

  // keep only the fields that the item kind uses
  always_comb begin
    packed_item = '0;
    if (op == OP_TAP) begin
      packed_item[PL_W-1] = OP_TAP;
      packed_item[ADDR_W+COEF_BITS-1:0] = {tap_index, tap_value};
    end else begin
      packed_item[PL_W-1] = OP_SAMPLE;
      packed_item[2*SAMPLE_BITS-1:0] = {sample_re, sample_im};
    end
  end

  par_fifo #(.WIDTH(PL_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wdata (packed_item),
    .full  (full),
    .rd    (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;
endmodule

/* rtl/par_back.sv */
// Back end: tap store, delay line, phase tracking and the shared-multiplier
// filter engine. Depends on par_pkg and par_ram.
module par_back #(
  parameter int NUM_PHASES     = par_pkg::DEF_NUM_PHASES,
  parameter int TAPS_PER_PHASE = par_pkg::DEF_TAPS_PER_PHASE,
  parameter int SAMPLE_BITS    = par_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS      = par_pkg::DEF_COEF_BITS,
  parameter int PL_W           = 1 + 2 * par_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [par_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [par_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_valid,
  input  logic [PL_W-1:0]                 q_data,
  output logic                            q_pop,
  output logic                            res_push,
  input  logic                            res_ready,
  output logic [2*SAMPLE_BITS:0]          res_data
);
  import par_pkg::*;

  localparam int PHW = $clog2(NUM_PHASES);
  // room for the last phase plus the widest step and a carry
  localparam int JW  = $clog2(NUM_PHASES + 64);
  localparam int KW0 = $clog2(NUM_PHASES * TAPS_PER_PHASE) + 1;
  localparam int KW  = (KW0 > LEN_W) ? KW0 : LEN_W + 1;
  localparam int TW  = (TAPS_PER_PHASE > 1) ? $clog2(TAPS_PER_PHASE) : 1;
  localparam int DW  = COEF_BITS + 1;
  localparam int PW  = SAMPLE_BITS + DW;
  localparam int AW  = PW + TW + 1;
  localparam int SW  = AW + 9;
  localparam int YW  = AW + 2;

  state_t state, state_next;

  logic [ISTEP_W-1:0] int_step;
  logic [FRAC_W-1:0]  frac_step;
  logic [LEN_W-1:0]   proto_len;

  logic signed [SAMPLE_BITS-1:0] dl_re [TAPS_PER_PHASE];
  logic signed [SAMPLE_BITS-1:0] dl_im [TAPS_PER_PHASE];

  logic [PHW-1:0]     phase_index;
  logic [FRAC_W-1:0]  frac;
  logic [CNT_W-1:0]   skip_count, wrap_count, n;
  logic [JW-1:0]      j, j_new;
  logic [KW-1:0]      k, k_p1, len_k;
  logic [TW-1:0]      t;
  logic [1:0]         bsel;
  logic [LEN_W-1:0]   eff_len;
  logic [ISTEP_W-1:0] step;
  logic [FRAC_W:0]    frac_sum;

  logic [ADDR_W-1:0]  a_addr, b_addr, ram_raddr;
  logic               ram_we;
  logic signed [COEF_BITS-1:0] ram_rdata, ha;
  logic signed [DW-1:0]        h, d;

  logic signed [SAMPLE_BITS-1:0] mul_a;
  logic signed [DW-1:0]          mul_b;
  logic signed [PW-1:0]          prod;
  logic                          acc_vld;
  logic [1:0]                    acc_idx;
  logic signed [AW-1:0]          acc [4];
  logic signed [AW-1:0]          r_re, r_im;
  logic signed [SW-1:0]          sc_re, sc_im;
  logic signed [AW:0]            y_re, y_im;
  logic signed [YW-1:0]          rnd_re, rnd_im;
  logic signed [SAMPLE_BITS-1:0] o_re, o_im;
  logic                          o_last;

  logic                          q_op;
  logic signed [SAMPLE_BITS-1:0] q_re, q_im;
  logic [ADDR_W-1:0]             q_idx;
  logic signed [COEF_BITS-1:0]   q_val;

  assign q_op  = q_data[PL_W-1];
  assign q_re  = q_data[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign q_im  = q_data[SAMPLE_BITS-1:0];
  assign q_idx = q_data[ADDR_W+COEF_BITS-1:COEF_BITS];
  assign q_val = q_data[COEF_BITS-1:0];

  par_ram #(.WIDTH(COEF_BITS), .DEPTH(STORE_DEPTH)) u_taps (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_idx),
    .wdata (q_val),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamp the prototype length to 2..512
  always_comb begin
    if (proto_len < LEN_W'(2)) begin
      eff_len = LEN_W'(2);
    end else if (proto_len > LEN_W'(STORE_DEPTH)) begin
      eff_len = LEN_W'(STORE_DEPTH);
    end else begin
      eff_len = proto_len;
    end
  end

  assign len_k  = KW'(eff_len);
  assign k_p1   = k + 1'b1;
  assign a_addr = k[ADDR_W-1:0];
  // last tap repeats the previous difference
  assign b_addr = (k_p1 < len_k) ? k_p1[ADDR_W-1:0] : a_addr - 1'b1;

  assign step     = (int_step == '0) ? ISTEP_W'(1) : int_step;
  assign frac_sum = {1'b0, frac} + {1'b0, frac_step};
  assign j_new    = j + JW'(step) + JW'(frac_sum[FRAC_W]);
  assign o_last   = !((j_new < JW'(NUM_PHASES)) && (n + 1'b1 < CNT_W'(MAX_OUT)));

  assign mul_a = (state == S_M0 || state == S_M2) ? dl_re[0] : dl_im[0];
  assign mul_b = (state == S_M0 || state == S_M1) ? h : d;

  assign sc_re = SW'(r_re) + SW'(acc[2]) * $signed({1'b0, frac[8*bsel +: 8]});
  assign sc_im = SW'(r_im) + SW'(acc[3]) * $signed({1'b0, frac[8*bsel +: 8]});

  assign rnd_re = (YW'(y_re) + YW'(1 <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);
  assign rnd_im = (YW'(y_im) + YW'(1 <<< (COEF_BITS - 2))) >>> (COEF_BITS - 1);

  always_comb begin
    if (rnd_re > YW'((1 <<< (SAMPLE_BITS - 1)) - 1)) begin
      o_re = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (rnd_re < -YW'(1 <<< (SAMPLE_BITS - 1))) begin
      o_re = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      o_re = rnd_re[SAMPLE_BITS-1:0];
    end
    if (rnd_im > YW'((1 <<< (SAMPLE_BITS - 1)) - 1)) begin
      o_im = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (rnd_im < -YW'(1 <<< (SAMPLE_BITS - 1))) begin
      o_im = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      o_im = rnd_im[SAMPLE_BITS-1:0];
    end
  end

  assign res_data = {o_re, o_im, o_last};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = a_addr;
    res_push   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_op == OP_TAP) begin
            ram_we = 1'b1;
          end else if (skip_count == '0) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        if (j < JW'(NUM_PHASES) && n < CNT_W'(MAX_OUT)) begin
          state_next = S_RA;
        end else begin
          state_next = S_WRAP;
        end
      end
      S_RA: state_next = S_RB;
      S_RB: begin
        ram_raddr  = b_addr;
        state_next = S_HD;
      end
      S_HD: state_next = S_M0;
      S_M0: state_next = S_M1;
      S_M1: state_next = S_M2;
      S_M2: state_next = S_M3;
      S_M3: state_next = (t == TW'(TAPS_PER_PHASE - 1)) ? S_DRAIN : S_RA;
      S_DRAIN: state_next = S_SC;
      S_SC: begin
        if (bsel == 2'd3) begin
          state_next = S_SUM;
        end
      end
      S_SUM: state_next = S_EMIT;
      S_EMIT: begin
        if (res_ready) begin
          res_push   = 1'b1;
          state_next = S_START;
        end
      end
      S_WRAP: begin
        if (j < JW'(NUM_PHASES)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // configuration, delay line and phase state
  always_ff @(posedge clk) begin
    if (rst) begin
      int_step    <= ISTEP_W'(1);
      frac_step   <= '0;
      proto_len   <= LEN_W'(STORE_DEPTH);
      phase_index <= '0;
      frac        <= '0;
      skip_count  <= '0;
      acc_vld     <= 1'b0;
      for (int i = 0; i < TAPS_PER_PHASE; i++) begin
        dl_re[i] <= '0;
        dl_im[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INT_STEP:  int_step  <= cfg_data[ISTEP_W-1:0];
          REG_FRAC_STEP: frac_step <= cfg_data[FRAC_W-1:0];
          REG_PROTO_LEN: proto_len <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      acc_vld <= (state == S_M0 || state == S_M1 || state == S_M2 || state == S_M3);
      if (state == S_IDLE && q_valid && q_op == OP_SAMPLE) begin
        dl_re[0] <= q_re;
        dl_im[0] <= q_im;
        for (int i = 1; i < TAPS_PER_PHASE; i++) begin
          dl_re[i] <= dl_re[i-1];
          dl_im[i] <= dl_im[i-1];
        end
        if (skip_count != '0) begin
          skip_count <= skip_count - 1'b1;
        end
      end
      // rotate so the next tap's sample sits at the head
      if (state == S_M3) begin
        dl_re[TAPS_PER_PHASE-1] <= dl_re[0];
        dl_im[TAPS_PER_PHASE-1] <= dl_im[0];
        for (int i = 0; i < TAPS_PER_PHASE - 1; i++) begin
          dl_re[i] <= dl_re[i+1];
          dl_im[i] <= dl_im[i+1];
        end
      end
      if (state == S_EMIT && res_ready) begin
        frac <= frac_sum[FRAC_W-1:0];
      end
      if (state == S_WRAP && j < JW'(NUM_PHASES)) begin
        phase_index <= j[PHW-1:0];
        if (wrap_count != '0) begin
          skip_count <= wrap_count - 1'b1;
        end
      end
    end
  end

  // engine datapath
  always_ff @(posedge clk) begin
    prod    <= mul_a * mul_b;
    acc_idx <= (state == S_M0) ? 2'd0 : (state == S_M1) ? 2'd1 :
               (state == S_M2) ? 2'd2 : 2'd3;
    if (acc_vld) begin
      acc[acc_idx] <= acc[acc_idx] + AW'(prod);
    end
    case (state)
      S_IDLE: begin
        j          <= JW'(phase_index);
        n          <= '0;
        wrap_count <= '0;
      end
      S_START: begin
        for (int i = 0; i < 4; i++) begin
          acc[i] <= '0;
        end
        k <= KW'(j);
        t <= '0;
      end
      S_RB: ha <= ram_rdata;
      S_HD: begin
        if (k < len_k) begin
          h <= DW'(ha);
          if (k_p1 < len_k) begin
            d <= DW'(ram_rdata) - DW'(ha);
          end else begin
            d <= DW'(ha) - DW'(ram_rdata);
          end
        end else begin
          h <= '0;
          d <= '0;
        end
      end
      S_M3: begin
        k <= k + KW'(NUM_PHASES);
        t <= t + 1'b1;
      end
      S_DRAIN: begin
        bsel <= '0;
        r_re <= '0;
        r_im <= '0;
      end
      S_SC: begin
        r_re <= AW'(sc_re >>> 8);
        r_im <= AW'(sc_im >>> 8);
        bsel <= bsel + 1'b1;
      end
      S_SUM: begin
        y_re <= (AW+1)'(acc[0]) + (AW+1)'(r_re);
        y_im <= (AW+1)'(acc[1]) + (AW+1)'(r_im);
      end
      S_EMIT: begin
        if (res_ready) begin
          j <= j_new;
          n <= n + 1'b1;
        end
      end
      S_WRAP: begin
        if (j >= JW'(NUM_PHASES)) begin
          j          <= j - JW'(NUM_PHASES);
          wrap_count <= wrap_count + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/polyphase_arbitrary_resampler.sv */
// Top level of the polyphase arbitrary resampler.
// Depends on par_pkg, par_front, par_back and par_fifo.

// The engine takes a tap write, or a sample that is skipped, without leaving
// its idle state. A sample that yields outputs also goes through the phase
// wrap, and each of its outputs is paced by the single shared multiplier
// doing four products per tap and the single read port of the tap memory
// giving two taps per derivative. Two-entry queues on input and output let
// each side stall on its own; configuration is always ready and is meant to
// be written while the block is idle.
module polyphase_arbitrary_resampler #(
  parameter int NUM_PHASES     = par_pkg::DEF_NUM_PHASES,
  parameter int TAPS_PER_PHASE = par_pkg::DEF_TAPS_PER_PHASE,
  parameter int SAMPLE_BITS    = par_pkg::DEF_SAMPLE_BITS,
  parameter int COEF_BITS      = par_pkg::DEF_COEF_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic                           op,
  input  logic signed [SAMPLE_BITS-1:0]  sample_re,
  input  logic signed [SAMPLE_BITS-1:0]  sample_im,
  input  logic [par_pkg::ADDR_W-1:0]     tap_index,
  input  logic signed [COEF_BITS-1:0]    tap_value,
  input  logic                           pop,
  output logic                           empty,
  output logic signed [SAMPLE_BITS-1:0]  out_re,
  output logic signed [SAMPLE_BITS-1:0]  out_im,
  output logic                           last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [par_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [par_pkg::CFG_DATA_W-1:0] cfg_data
);
  import par_pkg::*;

  localparam int SMP_PL = 2 * SAMPLE_BITS;
  localparam int TAP_PL = ADDR_W + COEF_BITS;
  localparam int PL_W   = 1 + ((SMP_PL > TAP_PL) ? SMP_PL : TAP_PL);
  localparam int RW     = 2 * SAMPLE_BITS + 1;

  logic            q_valid, q_pop;
  logic [PL_W-1:0] q_data;
  logic            res_push, res_full;
  logic [RW-1:0]   res_data, res_head;

  assign cfg_ready = 1'b1;

  par_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .PL_W        (PL_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .sample_re (sample_re),
    .sample_im (sample_im),
    .tap_index (tap_index),
    .tap_value (tap_value),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  par_back #(
    .NUM_PHASES     (NUM_PHASES),
    .TAPS_PER_PHASE (TAPS_PER_PHASE),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_BITS      (COEF_BITS),
    .PL_W           (PL_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_push  (res_push),
    .res_ready (!res_full),
    .res_data  (res_data)
  );

  par_fifo #(.WIDTH(RW), .DEPTH(QUEUE_DEPTH)) u_results (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_push),
    .wdata (res_data),
    .full  (res_full),
    .rd    (pop),
    .rdata (res_head),
    .empty (empty)
  );

  assign out_re = res_head[RW-1:SAMPLE_BITS+1];
  assign out_im = res_head[SAMPLE_BITS:1];
  assign last   = res_head[0];
endmodule

/* rtl/par_checker.sv */
// Port-level checks for the polyphase arbitrary resampler, bound to the top.
// Depends on par_pkg and polyphase_arbitrary_resampler_macros.svh.
`include "polyphase_arbitrary_resampler_macros.svh"

module par_checker #(
  parameter int SAMPLE_BITS = par_pkg::DEF_SAMPLE_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [SAMPLE_BITS-1:0] out_re,
  input logic [SAMPLE_BITS-1:0] out_im,
  input logic                   last
);
  // reset leaves no result waiting and room for input
  `PAR_ASSERT_ALWAYS(a_reset_empty, rst |=> empty, "result queue not empty after reset")
  `PAR_ASSERT_ALWAYS(a_reset_room, rst |=> !full, "input queue full after reset")
  // a waiting result is not withdrawn nor changed until taken
  `PAR_ASSERT(a_result_held, !empty && !pop |=> !empty, "waiting result withdrawn")
  `PAR_ASSERT(a_result_stable, !empty && !pop |=> $stable({out_re, out_im, last}), "result changed")
endmodule

bind polyphase_arbitrary_resampler par_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_par_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .out_re (out_re),
  .out_im (out_im),
  .last   (last)
);

/* verif/polyphase_arbitrary_resampler_tb.sv */
// Self-checking testbench for polyphase_arbitrary_resampler.
// Needs par_pkg and the resampler RTL. Carries its own bit-exact predictor of the
// filter bank and interpolation, and a directed table followed by random phases.
module polyphase_arbitrary_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import par_pkg::*;

  localparam int PHASES = 32;
  localparam int TAPS   = 16;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               lst;
  } outcome_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t                kind;
    logic [CFG_IDX_W-1:0]     reg_idx;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic                     opc;
    logic signed [15:0]       s_re;
    logic signed [15:0]       s_im;
    logic [ADDR_W-1:0]        t_idx;
    logic signed [17:0]       t_val;
    bit                       known;
    logic signed [15:0]       k_re;
    logic signed [15:0]       k_im;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, op = 1'b0, pop = 1'b0;
  logic signed [15:0] sample_re = '0, sample_im = '0;
  logic [ADDR_W-1:0] tap_index = '0;
  logic signed [17:0] tap_value = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic full, empty, last, cfg_ready;
  logic signed [15:0] out_re, out_im;

  polyphase_arbitrary_resampler uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .sample_re(sample_re), .sample_im(sample_im), .tap_index(tap_index),
    .tap_value(tap_value), .pop(pop), .empty(empty), .out_re(out_re),
    .out_im(out_im), .last(last), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  logic signed [17:0] coef_mem [STORE_DEPTH];
  bit                 coef_written [STORE_DEPTH];
  longint             hist_re [TAPS];
  longint             hist_im [TAPS];
  int unsigned        phase_pos, skip_left;
  logic [31:0]        frac_acc;
  logic [5:0]         istep_reg;
  logic [31:0]        fstep_reg;
  logic [9:0]         plen_reg;

  outcome_t expected_outputs[$];
  int  err_count = 0;
  int  items_sent = 0;
  int  outputs_seen = 0;
  bit  hold_done = 0;
  int  hold_left = 0;

  function automatic int unsigned active_len();
    if (plen_reg < 2) return 2;
    if (plen_reg > STORE_DEPTH) return STORE_DEPTH;
    return 32'(plen_reg);
  endfunction

  function automatic longint coef_at(int unsigned k);
    if (k >= active_len()) return 0;
    return longint'(coef_mem[k]);
  endfunction

  function automatic longint slope_at(int unsigned k);
    int unsigned l;
    l = active_len();
    if (k + 1 < l) return coef_at(k + 1) - coef_at(k);
    if (k + 1 == l) return coef_at(l - 1) - coef_at(l - 2);
    return 0;
  endfunction

  // floor(d * a / 2^32) one byte at a time
  function automatic longint frac_scale(longint d, logic [31:0] a);
    longint r;
    r = 0;
    for (int b = 0; b < 4; b++) r = (r + d * longint'(a[8*b +: 8])) >>> 8;
    return r;
  endfunction

  function automatic logic [15:0] round_sat(longint y);
    longint r;
    r = (y + (longint'(1) << 16)) >>> 17;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  task automatic reset_model();
    foreach (hist_re[t]) begin hist_re[t] = 0; hist_im[t] = 0; end
    foreach (coef_written[k]) coef_written[k] = 0;
    phase_pos = 0; skip_left = 0; frac_acc = '0;
    istep_reg = 6'd1; fstep_reg = '0; plen_reg = 10'd512;
  endtask

  task automatic resample_sample(logic signed [15:0] s_re, logic signed [15:0] s_im,
                                 bit known, logic signed [15:0] k_re,
                                 logic signed [15:0] k_im);
    int unsigned j, stp, n;
    longint p_re, p_im, d_re, d_im, h, d;
    logic [32:0] sum;
    outcome_t o;
    for (int t = TAPS - 1; t > 0; t--) begin
      hist_re[t] = hist_re[t-1];
      hist_im[t] = hist_im[t-1];
    end
    hist_re[0] = longint'(s_re);
    hist_im[0] = longint'(s_im);
    if (skip_left > 0) begin
      skip_left--;
      return;
    end
    stp = (istep_reg == '0) ? 1 : 32'(istep_reg);
    j = phase_pos;
    n = 0;
    while (j < PHASES && n < MAX_OUT) begin
      p_re = 0; p_im = 0; d_re = 0; d_im = 0;
      for (int t = 0; t < TAPS; t++) begin
        h = coef_at(j + t * PHASES);
        d = slope_at(j + t * PHASES);
        p_re += hist_re[t] * h;
        p_im += hist_im[t] * h;
        d_re += hist_re[t] * d;
        d_im += hist_im[t] * d;
      end
      o.re  = known ? k_re : round_sat(p_re + frac_scale(d_re, frac_acc));
      o.im  = known ? k_im : round_sat(p_im + frac_scale(d_im, frac_acc));
      o.lst = 1'b0;
      expected_outputs.insert(expected_outputs.size(), o);
      n++;
      sum = {1'b0, frac_acc} + {1'b0, fstep_reg};
      frac_acc = sum[31:0];
      j += stp + sum[32];
    end
    if (n > 0) expected_outputs[$].lst = 1'b1;
    if (j >= PHASES) begin
      skip_left = j / PHASES - 1;
      phase_pos = j % PHASES;
    end else begin
      phase_pos = j;
    end
  endtask

  // Sender: called just after a rising edge; returns at the accepting edge
  task automatic send_item(stim_row_t r);
    bit calm;
    calm = (items_sent >= 150 && items_sent < 230);
    while (!calm && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= r.opc;
    sample_re <= r.s_re;
    sample_im <= r.s_im;
    tap_index <= r.t_idx;
    tap_value <= r.t_val;
    do @(posedge clk); while (full);
    items_sent++;
    if (r.opc == OP_TAP) begin
      coef_mem[r.t_idx] = r.t_val;
      coef_written[r.t_idx] = 1;
    end else begin
      resample_sample(r.s_re, r.s_im, r.known, r.k_re, r.k_im);
    end
  endtask

  // Wait for every expected output, then let trailing skips and tap writes settle
  task automatic settle();
    push <= 1'b0;
    @(posedge clk);
    while (expected_outputs.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_INT_STEP:  istep_reg = val[5:0];
      REG_FRAC_STEP: fstep_reg = val;
      REG_PROTO_LEN: plen_reg = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic run_row(stim_row_t r);
    if (r.kind == ROW_CFG) begin
      settle();
      write_reg(r.reg_idx, r.reg_val);
    end else begin
      send_item(r);
    end
  endtask

  function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.reg_idx = idx; r.reg_val = val;
    return r;
  endfunction

  function automatic stim_row_t tap_row(int idx, int val);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.opc = OP_TAP; r.t_idx = ADDR_W'(idx); r.t_val = 18'(val);
    r.s_re = 16'($urandom); r.s_im = 16'($urandom);
    return r;
  endfunction

  function automatic stim_row_t smp_row(int s_re, int s_im);
    stim_row_t r;
    r = '{kind: ROW_ITEM, default: '0};
    r.opc = OP_SAMPLE; r.s_re = 16'(s_re); r.s_im = 16'(s_im);
    r.t_idx = ADDR_W'($urandom); r.t_val = 18'($urandom);
    return r;
  endfunction

  // Load every tap below the active length that has never been written
  task automatic fill_taps();
    for (int k = 0; k < active_len(); k++)
      if (!coef_written[k]) send_item(tap_row(k, $urandom));
  endtask

  stim_row_t plan[$];

  function automatic void plan_add(stim_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    stim_row_t r;
    int unsigned n_smp;
    reset_model();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero prototype: every output is zero whatever the samples
    plan_add(cfg_row(REG_PROTO_LEN, 0));
    plan_add(tap_row(0, 0));
    plan_add(tap_row(1, 0));
    r = smp_row(32767, -32768); r.known = 1; r.k_re = 0; r.k_im = 0;
    plan_add(r);
    // extreme taps, top store address written but beyond the length
    plan_add(tap_row(0, 131071));
    plan_add(tap_row(1, -131072));
    plan_add(tap_row(511, -131072));
    plan_add(smp_row(32767, 32767));
    plan_add(smp_row(-32768, -32768));
    plan_add(smp_row(-32768, 32767));
    plan_add(smp_row(0, 0));
    // zero integer step acts as one; a step of 32, all the phases, gives one output per sample
    plan_add(cfg_row(REG_INT_STEP, 0));
    plan_add(smp_row(12345, -23456));
    plan_add(cfg_row(REG_INT_STEP, 32));
    plan_add(smp_row(-1, 1));
    plan_add(smp_row(32767, -32768));
    // fractional carry pushes past a whole wrap: skipped samples
    plan_add(cfg_row(REG_FRAC_STEP, 32'hFFFF_FFFF));
    plan_add(smp_row(1000, -1000));
    plan_add(smp_row(-32768, 32767));
    plan_add(smp_row(32767, 32767));
    plan_add(smp_row(-5, 7));
    plan_add(cfg_row(REG_PROTO_LEN, 1));
    plan_add(cfg_row(REG_INT_STEP, 31));
    plan_add(cfg_row(REG_FRAC_STEP, 32'h8000_0000));
    plan_add(smp_row(-32768, -32768));
    plan_add(smp_row(4096, -4096));
    foreach (plan[i]) run_row(plan[i]);

    // random phases, each with its own register setting
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: write_reg(REG_PROTO_LEN, 160);
        default: write_reg(REG_PROTO_LEN, $urandom_range(2, 160));
      endcase
      write_reg(REG_INT_STEP, (ph == 1) ? 1 : (ph == 2) ? 32 : $urandom_range(3, 32));
      write_reg(REG_FRAC_STEP, (ph == 3) ? 0 : $urandom);
      fill_taps();
      n_smp = (ph == 1) ? 20 : 50;
      for (int i = 0; i < n_smp; i++) begin
        // occasional rewrite of a random tap address among the samples
        if ($urandom_range(99) < 10)
          send_item(tap_row($urandom_range(0, STORE_DEPTH - 1), $urandom));
        else
          send_item(smp_row($urandom, $urandom));
      end
    end

    settle();
    if (err_count == 0 && expected_outputs.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Receiver: random pops, one long hold-off once outputs have started flowing, then a stretch of steady pops
  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        outputs_seen++;
        if (expected_outputs.size() == 0) begin
          $error("unexpected output re=%0d im=%0d last=%0b", out_re, out_im, last);
          err_count++;
        end else begin
          e = expected_outputs.pop_front();
          if (out_re !== e.re) begin
            $error("out_re expected %0d got %0d", e.re, out_re); err_count++;
          end
          if (out_im !== e.im) begin
            $error("out_im expected %0d got %0d", e.im, out_im); err_count++;
          end
          if (last !== e.lst) begin
            $error("last expected %0b got %0b", e.lst, last); err_count++;
          end
        end
      end
      if (!hold_done && outputs_seen >= 60) begin
        hold_done <= 1;
        hold_left <= 600;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (outputs_seen >= 300 && outputs_seen < 500) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 19);
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/par_pkg.sv
rtl/par_ram.sv
rtl/par_fifo.sv
rtl/par_front.sv
rtl/par_back.sv
rtl/polyphase_arbitrary_resampler.sv
rtl/par_checker.sv
verif/polyphase_arbitrary_resampler_tb.sv
